// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled while rst_n is
// low. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RH_ASSERT(lbl, prop, msg)
`define RH_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV package
// Fixed widths, hue sector codes and the sideband that travels beside the
// dividers.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

  // Hue is counted in 1/1536 of a turn: six sectors of 256 steps.
  localparam int HUE_W     = 11;
  localparam int HUE_FRAC  = 8;
  localparam int HUE_QW    = HUE_FRAC + 1;
  localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(6 << HUE_FRAC);

  // Quotient bits retired by each divider stage.
  localparam int DIV_STEPS = 2;

  typedef enum logic [1:0] {
    SECT_1 = 2'd0,
    SECT_3 = 2'd1,
    SECT_5 = 2'd2
  } sector_t;

  typedef struct packed {
    sector_t sector;
    logic    neg;
    logic    zero;
  } side_t;

  function automatic logic [HUE_W-1:0] sector_base(input sector_t sector);
    logic [HUE_W-1:0] base;
    unique case (sector)
      SECT_1:  base = HUE_W'(1 << HUE_FRAC);
      SECT_3:  base = HUE_W'(3 << HUE_FRAC);
      SECT_5:  base = HUE_W'(5 << HUE_FRAC);
      default: base = '0;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rgbhsv_front.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV front stage
// Finds the largest and smallest component, the span, the sector and the
// signed difference, and sets up the operands of both dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_front
  import rgbhsv_pkg::*;
#(
  parameter int COMPONENT_BITS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [COMPONENT_BITS-1:0] red,
  input  wire logic [COMPONENT_BITS-1:0] green,
  input  wire logic [COMPONENT_BITS-1:0] blue,
  input  wire logic [COMPONENT_BITS-1:0] alpha,
  output side_t                          side_o,
  output logic [COMPONENT_BITS-1:0]      hrem_o,
  output logic [HUE_QW-1:0]              hlq_o,
  output logic [COMPONENT_BITS-1:0]      hdiv_o,
  output logic [COMPONENT_BITS-1:0]      srem_o,
  output logic [COMPONENT_BITS-1:0]      slq_o,
  output logic [COMPONENT_BITS-1:0]      sdiv_o,
  output logic [COMPONENT_BITS-1:0]      alpha_o
);

  localparam int N = COMPONENT_BITS;

  logic [N-1:0] lo_rg, hi_rg, lo, hi, d, x, y, absf;
  logic         fge;
  sector_t      sector;
  side_t        side_nxt;

  side_t        side_r;
  logic [N-1:0] hrem_r, hdiv_r, srem_r, slq_r, sdiv_r, alpha_r;
  logic [HUE_QW-1:0] hlq_r;

  always_comb begin
    lo_rg = (red < green) ? red : green;
    lo    = (blue < lo_rg) ? blue : lo_rg;
    hi_rg = (red > green) ? red : green;
    hi    = (blue > hi_rg) ? blue : hi_rg;
    d     = hi - lo;

    // Red wins ties for smallest, then green.
    priority if (red == lo) begin
      x = green;
      y = blue;
      sector = SECT_3;
    end else if (green == lo) begin
      x = blue;
      y = red;
      sector = SECT_5;
    end else begin
      x = red;
      y = green;
      sector = SECT_1;
    end

    fge  = (x >= y);
    absf = fge ? (x - y) : (y - x);

    side_nxt.sector = sector;
    side_nxt.neg    = !fge;
    side_nxt.zero   = (hi == lo);
  end

  // The hue numerator is |f| * 256; its top N bits start the remainder.
  // The saturation numerator d * (2^N - 1) splits into (d - 1) above and
  // (2^N - d) below the binary point.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r  <= side_nxt;
      hrem_r  <= {1'b0, absf[N-1:1]};
      hlq_r   <= {absf[0], {HUE_FRAC{1'b0}}};
      hdiv_r  <= d;
      srem_r  <= d - N'(1);
      slq_r   <= lo - hi;
      sdiv_r  <= hi;
      alpha_r <= alpha;
    end
  end

  assign side_o  = side_r;
  assign hrem_o  = hrem_r;
  assign hlq_o   = hlq_r;
  assign hdiv_o  = hdiv_r;
  assign srem_o  = srem_r;
  assign slq_o   = slq_r;
  assign sdiv_o  = sdiv_r;
  assign alpha_o = alpha_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rgbhsv_div.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV pipelined divider
// Restoring division spread over a chain of register stages, a fixed number
// of quotient bits per stage. The dividend's low bits and the quotient share
// one shift register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_div
  import rgbhsv_pkg::*;
#(
  parameter int DW     = 8,
  parameter int QW     = 8,
  parameter int STAGES = 5
) (
  input  wire logic              clk,
  input  wire logic [STAGES-1:0] en,
  input  wire logic [DW-1:0]     in_rem,
  input  wire logic [QW-1:0]     in_lq,
  input  wire logic [DW-1:0]     in_div,
  output logic [QW-1:0]          quo
);

  logic [DW-1:0] rem_src [STAGES];
  logic [QW-1:0] lq_src  [STAGES];
  logic [DW-1:0] dv_src  [STAGES];
  logic [DW-1:0] rem_res [STAGES];
  logic [QW-1:0] lq_res  [STAGES];

  logic [DW-1:0] rem_r [STAGES-1];
  logic [DW-1:0] dv_r  [STAGES-1];
  logic [QW-1:0] lq_r  [STAGES];

  // Steps numbered at or beyond the quotient width leave the operands as
  // they are, so short quotients simply ride through the later stages.
  function automatic logic [DW+QW-1:0] div_steps(
    input logic [DW-1:0] rem_i,
    input logic [QW-1:0] lq_i,
    input logic [DW-1:0] dv,
    input int            first
  );
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem;
    logic [QW-1:0] lq;
    rem  = rem_i;
    lq   = lq_i;
    t    = '0;
    diff = '0;
    ge   = 1'b0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (first + k < QW) begin
        t    = {rem, lq[QW-1]};
        diff = t - {1'b0, dv};
        ge   = (t >= {1'b0, dv});
        rem  = ge ? diff[DW-1:0] : t[DW-1:0];
        lq   = {lq[QW-2:0], ge};
      end
    end
    return {rem, lq};
  endfunction

  always_comb begin
    rem_src[0] = in_rem;
    lq_src[0]  = in_lq;
    dv_src[0]  = in_div;
    for (int s = 1; s < STAGES; s++) begin
      rem_src[s] = rem_r[s-1];
      lq_src[s]  = lq_r[s-1];
      dv_src[s]  = dv_r[s-1];
    end
    for (int s = 0; s < STAGES; s++) begin
      {rem_res[s], lq_res[s]} = div_steps(rem_src[s], lq_src[s], dv_src[s],
                                          s * DIV_STEPS);
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      if (en[s]) begin
        lq_r[s] <= lq_res[s];
      end
    end
    for (int s = 0; s < STAGES - 1; s++) begin
      if (en[s]) begin
        rem_r[s] <= rem_res[s];
        dv_r[s]  <= dv_src[s];
      end
    end
  end

  assign quo = lq_r[STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/rgbhsv_back.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV output stage
// Subtracts the signed quotient from the sector base, clears hue and
// saturation for grey pixels and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_back
  import rgbhsv_pkg::*;
#(
  parameter int COMPONENT_BITS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire side_t                     side_i,
  input  wire logic [HUE_QW-1:0]         hq_i,
  input  wire logic [COMPONENT_BITS-1:0] sq_i,
  input  wire logic [COMPONENT_BITS-1:0] bright_i,
  input  wire logic [COMPONENT_BITS-1:0] alpha_i,
  output logic [HUE_W-1:0]               hue_o,
  output logic [COMPONENT_BITS-1:0]      sat_o,
  output logic [COMPONENT_BITS-1:0]      bright_o,
  output logic [COMPONENT_BITS-1:0]      alpha_o
);

  logic [HUE_W-1:0]          base, qx, hue_nxt;
  logic [COMPONENT_BITS-1:0] sat_nxt;

  logic [HUE_W-1:0]          hue_r;
  logic [COMPONENT_BITS-1:0] sat_r, bright_r, alpha_r;

  always_comb begin
    base = sector_base(side_i.sector);
    qx   = HUE_W'(hq_i);
    // A negative difference truncates toward zero, so its quotient is added.
    priority if (side_i.zero) begin
      hue_nxt = '0;
    end else if (side_i.neg) begin
      hue_nxt = base + qx;
    end else begin
      hue_nxt = base - qx;
    end
    sat_nxt = side_i.zero ? '0 : sq_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= bright_i;
      alpha_r  <= alpha_i;
    end
  end

  assign hue_o    = hue_r;
  assign sat_o    = sat_r;
  assign bright_o = bright_r;
  assign alpha_o  = alpha_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_to_hsv.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Streaming colour conversion: one pixel in and one HSV pixel out per beat.
// ----------------------------------------------------------------------------
// The converter accepts a pixel in every clock cycle unless an output stall
// has filled its stages, and passes it through one front stage, the two
// restoring dividers for hue and saturation running side by side at two
// quotient bits per stage, and an output register. Hue is in 1/1536 of a
// turn with pure red at 1536, and saturation is span times full scale over
// value, truncated. A stall on the output fills the empty stages first and
// only then stalls the input.
`default_nettype none
`include "assert_macros.svh"

module rgb_to_hsv
  import rgbhsv_pkg::*;
#(
  parameter int COMPONENT_BITS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [COMPONENT_BITS-1:0] in_red,
  input  wire logic [COMPONENT_BITS-1:0] in_green,
  input  wire logic [COMPONENT_BITS-1:0] in_blue,
  input  wire logic [COMPONENT_BITS-1:0] in_alpha_in,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [HUE_W-1:0]               out_hue,
  output logic [COMPONENT_BITS-1:0]      out_saturation,
  output logic [COMPONENT_BITS-1:0]      out_brightness,
  output logic [COMPONENT_BITS-1:0]      out_alpha_out
);

  localparam int N    = COMPONENT_BITS;
  localparam int MAXQ = (N > HUE_QW) ? N : HUE_QW;
  localparam int DSTG = (MAXQ + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NSTG = DSTG + 2;

  logic [NSTG-1:0] v_r, v_nxt, en;
  logic [NSTG:0]   rdy;

  side_t        f_side;
  logic [N-1:0] f_hrem, f_hdiv, f_srem, f_slq, f_sdiv, f_alpha;
  logic [HUE_QW-1:0] f_hlq;

  side_t        side_r   [DSTG];
  logic [N-1:0] bright_r [DSTG];
  logic [N-1:0] alpha_r  [DSTG];

  logic [HUE_QW-1:0] hue_q;
  logic [N-1:0]      sat_q;

  // A stage takes a new beat when it is empty or its successor moves on.
  always_comb begin
    rdy[NSTG] = !out_stall;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    en[0]    = rdy[0] && in_valid;
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int i = 1; i < NSTG; i++) begin
      en[i]    = rdy[i] && v_r[i-1];
      v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  rgbhsv_front #(
    .COMPONENT_BITS(N)
  ) u_front (
    .clk     (clk),
    .en      (en[0]),
    .red     (in_red),
    .green   (in_green),
    .blue    (in_blue),
    .alpha   (in_alpha_in),
    .side_o  (f_side),
    .hrem_o  (f_hrem),
    .hlq_o   (f_hlq),
    .hdiv_o  (f_hdiv),
    .srem_o  (f_srem),
    .slq_o   (f_slq),
    .sdiv_o  (f_sdiv),
    .alpha_o (f_alpha)
  );

  rgbhsv_div #(
    .DW     (N),
    .QW     (HUE_QW),
    .STAGES (DSTG)
  ) u_hue_div (
    .clk    (clk),
    .en     (en[DSTG:1]),
    .in_rem (f_hrem),
    .in_lq  (f_hlq),
    .in_div (f_hdiv),
    .quo    (hue_q)
  );

  rgbhsv_div #(
    .DW     (N),
    .QW     (N),
    .STAGES (DSTG)
  ) u_sat_div (
    .clk    (clk),
    .en     (en[DSTG:1]),
    .in_rem (f_srem),
    .in_lq  (f_slq),
    .in_div (f_sdiv),
    .quo    (sat_q)
  );

  // Sideband travels in step with the divider stages.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      side_r[0]   <= f_side;
      bright_r[0] <= f_sdiv;
      alpha_r[0]  <= f_alpha;
    end
    for (int j = 1; j < DSTG; j++) begin
      if (en[j+1]) begin
        side_r[j]   <= side_r[j-1];
        bright_r[j] <= bright_r[j-1];
        alpha_r[j]  <= alpha_r[j-1];
      end
    end
  end

  rgbhsv_back #(
    .COMPONENT_BITS(N)
  ) u_back (
    .clk      (clk),
    .en       (en[NSTG-1]),
    .side_i   (side_r[DSTG-1]),
    .hq_i     (hue_q),
    .sq_i     (sat_q),
    .bright_i (bright_r[DSTG-1]),
    .alpha_i  (alpha_r[DSTG-1]),
    .hue_o    (out_hue),
    .sat_o    (out_saturation),
    .bright_o (out_brightness),
    .alpha_o  (out_alpha_out)
  );

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NSTG-1];

  `RH_ASSERT(a_stall_only_when_full, in_stall |-> (out_valid && out_stall), "input stalled while the output is free")
  `RH_ASSERT(a_hue_in_range, out_valid |-> (out_hue <= HUE_MAX), "hue beyond a full turn")
  `RH_ASSERT(a_black_is_grey, (out_valid && (out_brightness == '0)) |-> ((out_hue == '0) && (out_saturation == '0)), "black pixel with hue or saturation")

endmodule

`default_nettype wire

// ===== verif/tb_rgb_to_hsv.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Drives directed and random pixels through the converter with bursty input
// and a patterned output stall. Each accepted pixel is converted by an
// integer model in the scoreboard, and every output beat is checked field by
// field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [rgbhsv_pkg::HUE_W-1:0] hue;
  logic [7:0]                   saturation;
  logic [7:0]                   brightness;
  logic [7:0]                   alpha;
} hsv_pixel_t;

class hsv_scoreboard;
  localparam int FULL_SCALE = 255;

  hsv_pixel_t awaited_hsv[$];
  int         errors;

  function new();
    errors = 0;
  endfunction

  function int pending();
    return awaited_hsv.size();
  endfunction

  // Integer conversion: hue in 1/1536 turn, pure red lands on 1536.
  function hsv_pixel_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] a);
    hsv_pixel_t res;
    int ri, gi, bi, lo, hi, span, diff, base, hue_val;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    lo = (ri < gi) ? ri : gi;
    if (bi < lo) lo = bi;
    hi = (ri > gi) ? ri : gi;
    if (bi > hi) hi = bi;
    span = hi - lo;
    res.alpha      = a;
    res.brightness = hi[7:0];
    if (span == 0) begin
      res.hue        = '0;
      res.saturation = '0;
    end else begin
      // Red is tested first when two components share the minimum.
      if (ri == lo) begin
        diff = gi - bi;
        base = 3;
      end else if (gi == lo) begin
        diff = bi - ri;
        base = 5;
      end else begin
        diff = ri - gi;
        base = 1;
      end
      // Signed division truncates towards zero, as the hue needs.
      hue_val        = base * 256 - (diff * 256) / span;
      res.hue        = hue_val[rgbhsv_pkg::HUE_W-1:0];
      res.saturation = 8'((span * FULL_SCALE) / hi);
    end
    return res;
  endfunction

  function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    awaited_hsv.push_back(convert_pixel(r, g, b, a));
  endfunction

  function void check_result(hsv_pixel_t got);
    hsv_pixel_t exp_px;
    if (awaited_hsv.size() == 0) begin
      $display("%0t: output beat with nothing awaited: hue %0d sat %0d val %0d alpha %0d",
               $time, got.hue, got.saturation, got.brightness, got.alpha);
      errors++;
      return;
    end
    exp_px = awaited_hsv.pop_front();
    if (got.hue !== exp_px.hue) begin
      $display("%0t: hue expected %0d actual %0d", $time, exp_px.hue, got.hue);
      errors++;
    end
    if (got.saturation !== exp_px.saturation) begin
      $display("%0t: saturation expected %0d actual %0d", $time, exp_px.saturation,
               got.saturation);
      errors++;
    end
    if (got.brightness !== exp_px.brightness) begin
      $display("%0t: brightness expected %0d actual %0d", $time, exp_px.brightness,
               got.brightness);
      errors++;
    end
    if (got.alpha !== exp_px.alpha) begin
      $display("%0t: alpha expected %0d actual %0d", $time, exp_px.alpha, got.alpha);
      errors++;
    end
  endfunction
endclass

module tb_rgb_to_hsv;
  import rgbhsv_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int LATENCY      = 7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_RUNS
  } stall_mode_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_red;
  logic [7:0]       in_green;
  logic [7:0]       in_blue;
  logic [7:0]       in_alpha_in;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [HUE_W-1:0] out_hue;
  logic [7:0]       out_saturation;
  logic [7:0]       out_brightness;
  logic [7:0]       out_alpha_out;

  hsv_scoreboard sb = new();
  int            cycle_count = 0;
  stall_mode_t   stall_mode = STALL_NONE;
  int            mode_left = 0;
  int            run_left = 0;

  rgb_to_hsv #(
    .COMPONENT_BITS(8)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_alpha_in   (in_alpha_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_brightness(out_brightness),
    .out_alpha_out (out_alpha_out)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pixel(in_red, in_green, in_blue, in_alpha_in);
      if (out_valid && !out_stall)
        sb.check_result({out_hue, out_saturation, out_brightness, out_alpha_out});
    end
  end

  // The receiver switches at random between stall patterns.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 20);
          out_stall <= ~out_stall;
        end else begin
          run_left--;
        end
      end
    endcase
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] a);
    @(negedge clk);
    in_valid    <= 1'b1;
    in_red      <= r;
    in_green    <= g;
    in_blue     <= b;
    in_alpha_in <= a;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_input(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    pause_input(0);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly uniform pixels, with a share of ties, greys and extreme values.
  task automatic send_random_pixel();
    logic [7:0] r, g, b, a;
    logic [7:0] corner[4];
    int         style;
    corner = '{8'd0, 8'd1, 8'd254, 8'd255};
    r      = 8'($urandom);
    g      = 8'($urandom);
    b      = 8'($urandom);
    a      = 8'($urandom);
    style  = $urandom_range(0, 9);
    case (style)
      6: g = r;
      7: b = ($urandom_range(0, 1) != 0) ? r : g;
      8: begin
        r = corner[$urandom_range(0, 3)];
        g = corner[$urandom_range(0, 3)];
        b = corner[$urandom_range(0, 3)];
      end
      9: begin
        g = r;
        b = r;
      end
      default: ;
    endcase
    send_pixel(r, g, b, a);
  endtask

  initial begin
    int sent;
    int burst;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_red      = '0;
    in_green    = '0;
    in_blue     = '0;
    in_alpha_in = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Greys, primaries, pure red, ties on the minimum and a span of one.
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128, 8'd77);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd170);
    send_pixel(8'd0, 8'd0, 8'd255, 8'd85);
    send_pixel(8'd255, 8'd255, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd254);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd128);
    send_pixel(8'd255, 8'd254, 8'd254, 8'd3);
    send_pixel(8'd100, 8'd101, 8'd100, 8'd200);
    send_pixel(8'd100, 8'd100, 8'd101, 8'd50);
    send_pixel(8'd255, 8'd1, 8'd0, 8'd9);
    send_pixel(8'd0, 8'd1, 8'd255, 8'd90);
    send_pixel(8'd1, 8'd255, 8'd0, 8'd240);
    send_pixel(8'd200, 8'd50, 8'd51, 8'd15);
    send_pixel(8'd170, 8'd85, 8'd0, 8'd60);
    send_pixel(8'd1, 8'd1, 8'd1, 8'd127);
    send_pixel(8'd254, 8'd255, 8'd253, 8'd129);
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        send_random_pixel();
        burst--;
        sent++;
      end
      if (sent == RANDOM_ITEMS / 2) drain_results();
      else if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 8));
    end

    drain_results();
    repeat (LATENCY * 3) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== rgb_to_hsv.f =====
+incdir+hw/rtl
hw/rtl/rgbhsv_pkg.sv
hw/rtl/rgbhsv_front.sv
hw/rtl/rgbhsv_div.sv
hw/rtl/rgbhsv_back.sv
hw/rtl/rgb_to_hsv.sv
verif/tb_rgb_to_hsv.sv
